// ===== design/crcu_pkg.sv =====
// ----------------------------------------------------------------------------
// Cube rotation code unit package
// Shared types, the table of the 24 proper rotation codes and the field
// helpers used by the next-code and status logic.
// ----------------------------------------------------------------------------
package crcu_pkg;

   localparam int unsigned CodeWidth  = 18;
   localparam int unsigned FieldWidth = 3;
   localparam int unsigned NumFaces   = 6;
   localparam int unsigned NumCodes   = 24;

   typedef logic [CodeWidth-1:0]  code_type;
   typedef logic [FieldWidth-1:0] field_type;
   typedef logic [4:0]            tindex_type;
   typedef logic [1:0]            turns_type;

   // The spare command code behaves as a query.
   typedef enum logic [2:0] {
      CMD_LOAD    = 3'd0,
      CMD_TLOAD   = 3'd1,
      CMD_ROT_X   = 3'd2,
      CMD_ROT_Y   = 3'd3,
      CMD_ROT_Z   = 3'd4,
      CMD_COMPOSE = 3'd5,
      CMD_QUERY   = 3'd6,
      CMD_SPARE   = 3'd7
   } cmd_type;

   localparam code_type HOME_CODE = 18'd181896;

   localparam code_type VALID_CODES [NumCodes] = '{
      18'd5349,   18'd5804,   18'd6490,   18'd6931,   18'd34028,  18'd34469,
      18'd35155,  18'd35610,  18'd77932,  18'd78373,  18'd80193,  18'd80648,
      18'd106597, 18'd107052, 18'd108872, 18'd109313, 18'd151635, 18'd152090,
      18'd152776, 18'd153217, 18'd180314, 18'd180755, 18'd181441, 18'd181896
   };

   // Source field for each destination field of one quarter turn,
   // destination five first.
   typedef logic [NumFaces-1:0][FieldWidth-1:0] perm_type;
   localparam perm_type PERM_X = {3'd2, 3'd3, 3'd5, 3'd4, 3'd1, 3'd0};
   localparam perm_type PERM_Y = {3'd1, 3'd0, 3'd3, 3'd2, 3'd4, 3'd5};
   localparam perm_type PERM_Z = {3'd5, 3'd4, 3'd1, 3'd0, 3'd2, 3'd3};

   // Faces six and seven do not exist and read as zero.
   function automatic field_type field_of(input code_type code, input field_type f);
      logic [FieldWidth*8-1:0] ext;
      ext = {{(FieldWidth*8-CodeWidth){1'b0}}, code};
      return ext[f*FieldWidth +: FieldWidth];
   endfunction

   function automatic code_type permute(input code_type code, input perm_type src);
      code_type v;
      for (int i = 0; i < NumFaces; i++) begin
         v[i*FieldWidth +: FieldWidth] = field_of(code, src[i]);
      end
      return v;
   endfunction

endpackage

// ===== design/crcu_next.sv =====
// ----------------------------------------------------------------------------
// Cube rotation code next-state logic
// Computes the code that one command leaves behind: load, table load,
// quarter turns about an axis, composition with an operand, or hold.
// ----------------------------------------------------------------------------
module crcu_next
   import crcu_pkg::*;
(
   input  logic [2:0]  command,
   input  code_type    code_cur,
   input  code_type    code_operand,
   input  turns_type   turns,
   input  tindex_type  table_index,
   output code_type    code_next
);

   perm_type   perm_sel;
   code_type   turn1;
   code_type   turn2;
   code_type   turn3;
   code_type   turned;
   code_type   composed;
   tindex_type index_red;

   always_comb begin
      case (cmd_type'(command))
         CMD_ROT_Y: perm_sel = PERM_Y;
         CMD_ROT_Z: perm_sel = PERM_Z;
         default:   perm_sel = PERM_X;
      endcase
   end

   // Each quarter turn is pure rewiring, so three in a row cost only muxes.
   assign turn1 = permute(code_cur, perm_sel);
   assign turn2 = permute(turn1, perm_sel);
   assign turn3 = permute(turn2, perm_sel);

   always_comb begin
      case (turns)
         2'd1:    turned = turn1;
         2'd2:    turned = turn2;
         2'd3:    turned = turn3;
         default: turned = code_cur;
      endcase
   end

   always_comb begin
      for (int i = 0; i < NumFaces; i++) begin
         composed[i*FieldWidth +: FieldWidth] =
            field_of(code_cur, field_of(code_operand, field_type'(i)));
      end
   end

   assign index_red = (table_index >= tindex_type'(NumCodes)) ?
                      table_index - tindex_type'(NumCodes) : table_index;

   always_comb begin
      case (cmd_type'(command))
         CMD_LOAD:    code_next = code_operand;
         CMD_TLOAD:   code_next = VALID_CODES[index_red];
         CMD_ROT_X:   code_next = turned;
         CMD_ROT_Y:   code_next = turned;
         CMD_ROT_Z:   code_next = turned;
         CMD_COMPOSE: code_next = composed;
         default:     code_next = code_cur;
      endcase
   end

endmodule

// ===== design/crcu_status.sv =====
// ----------------------------------------------------------------------------
// Cube rotation code status logic
// Checks a code against the 24 proper rotation codes and picks the image
// of the requested face.
// ----------------------------------------------------------------------------
module crcu_status
   import crcu_pkg::*;
(
   input  code_type  code,
   input  field_type face_query,
   output logic      is_valid,
   output field_type face_image
);

   always_comb begin
      is_valid = 1'b0;
      for (int i = 0; i < NumCodes; i++) begin
         is_valid = is_valid | (code == VALID_CODES[i]);
      end
   end

   assign face_image = field_of(code, face_query);

endmodule

// ===== design/cube_rotation_code_unit.sv =====
// ----------------------------------------------------------------------------
// Cube rotation code unit
// Holds one cube rotation code and updates it by one command per item.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle while the result side takes
// results. An input register feeds the next-code and status logic, whose
// outputs load the current code and the result register together.
// The current code register closes the only loop, and each command resolves
// in combinational logic, so the sustained rate is one item per cycle for as
// long as the result side keeps taking results. After reset the code is the
// identity rotation.
module cube_rotation_code_unit
   import crcu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [17:0] req_code_operand,
   input  logic [1:0]  req_turns,
   input  logic [4:0]  req_table_index,
   input  logic [2:0]  req_face_query,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [17:0] rsp_code_out,
   output logic        rsp_is_valid,
   output logic [2:0]  rsp_face_image
);

   logic       in_valid_ff;
   logic [2:0] cmd_ff;
   code_type   operand_ff;
   turns_type  turns_ff;
   tindex_type index_ff;
   field_type  face_ff;

   code_type   code_ff;
   code_type   code_in;

   logic       out_valid_ff;
   code_type   out_code_ff;
   logic       out_is_valid_ff;
   field_type  out_face_ff;
   logic       status_valid;
   field_type  status_face;

   logic       advance;

   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         cmd_ff     <= req_command;
         operand_ff <= req_code_operand;
         turns_ff   <= req_turns;
         index_ff   <= req_table_index;
         face_ff    <= req_face_query;
      end
   end

   crcu_next u_next (
      .command      (cmd_ff),
      .code_cur     (code_ff),
      .code_operand (operand_ff),
      .turns        (turns_ff),
      .table_index  (index_ff),
      .code_next    (code_in)
   );

   crcu_status u_status (
      .code       (code_in),
      .face_query (face_ff),
      .is_valid   (status_valid),
      .face_image (status_face)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= HOME_CODE;
      end else if (advance) begin
         code_ff <= code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_code_ff     <= code_in;
         out_is_valid_ff <= status_valid;
         out_face_ff     <= status_face;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_out   = out_code_ff;
   assign rsp_is_valid   = out_is_valid_ff;
   assign rsp_face_image = out_face_ff;

   // A pending result always shows the code that the unit now holds.
   assert_result_matches_state : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_code_ff == code_ff))
      else $error("result code differs from held code");

   // Queries and unused command codes leave the held code alone.
   assert_query_holds_code : assert property (@(posedge clock) disable iff (reset)
      (advance && (cmd_ff == CMD_QUERY || cmd_ff == CMD_SPARE)) |=> $stable(code_ff))
      else $error("query changed the held code");

   // The input side stalls only while an item waits in the input register.
   assert_stall_has_item : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("input stalled without a blocked item");

endmodule

// ===== test/cube_rotation_code_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Cube rotation code unit testbench
// Drives commands into the unit through its request channel and predicts
// each result from a behavioral copy of the rotation code. Every result is
// compared field by field with the oldest prediction. Both channels idle in
// random bursts, the result side holds off for a long stretch once, and the
// last part of the run goes at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cube_rotation_code_unit_tb;
   import crcu_pkg::*;

   localparam int unsigned LONG_HOLD_CYCLES = 60;
   localparam int unsigned AXIS_X = 0;
   localparam int unsigned AXIS_Y = 1;
   localparam int unsigned AXIS_Z = 2;

   // Source field for each destination field of one quarter turn, per axis.
   localparam int unsigned TURN_SRC [3][6] = '{
      '{0, 1, 4, 5, 3, 2},
      '{5, 4, 2, 3, 0, 1},
      '{3, 2, 0, 1, 4, 5}
   };

   typedef struct {
      code_type  code;
      logic      valid;
      field_type face;
   } rotation_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_command = 3'd0;
   logic [17:0] req_code_operand = '0;
   logic [1:0]  req_turns = '0;
   logic [4:0]  req_table_index = '0;
   logic [2:0]  req_face_query = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [17:0] rsp_code_out;
   logic        rsp_is_valid;
   logic [2:0]  rsp_face_image;

   code_type            model_code;
   rotation_result_type predicted_results [$];
   int unsigned         error_count = 0;
   bit                  sender_idle_en = 1'b1;
   bit                  receiver_idle_en = 1'b1;
   bit                  long_hold_req = 1'b0;

   cube_rotation_code_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_code_operand (req_code_operand),
      .req_turns        (req_turns),
      .req_table_index  (req_table_index),
      .req_face_query   (req_face_query),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_out     (rsp_code_out),
      .rsp_is_valid     (rsp_is_valid),
      .rsp_face_image   (rsp_face_image)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic field_type face_at(input code_type c, input int unsigned f);
      if (f >= 6) return '0;
      return c[3*f +: 3];
   endfunction

   function automatic code_type turn_code(input code_type c, input int unsigned axis,
                                          input int unsigned n);
      code_type v;
      v = c;
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < 6; i++) begin
            v[3*i +: 3] = face_at(c, TURN_SRC[axis][i]);
         end
         c = v;
      end
      return c;
   endfunction

   function automatic code_type compose_code(input code_type c, input code_type op);
      code_type v;
      v = '0;
      for (int i = 0; i < 6; i++) begin
         v[3*i +: 3] = face_at(c, face_at(op, i));
      end
      return v;
   endfunction

   function automatic logic is_rotation(input code_type c);
      for (int i = 0; i < NumCodes; i++) begin
         if (c == VALID_CODES[i]) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advances the model code by one command and queues the result it gives.
   task automatic predict_rotation(input logic [2:0] cmd, input code_type op,
                                   input turns_type n, input tindex_type idx,
                                   input field_type fq);
      rotation_result_type r;
      case (cmd)
         CMD_LOAD:    model_code = op;
         CMD_TLOAD:   model_code = VALID_CODES[idx % NumCodes];
         CMD_ROT_X:   model_code = turn_code(model_code, AXIS_X, n);
         CMD_ROT_Y:   model_code = turn_code(model_code, AXIS_Y, n);
         CMD_ROT_Z:   model_code = turn_code(model_code, AXIS_Z, n);
         CMD_COMPOSE: model_code = compose_code(model_code, op);
         default:     model_code = model_code;
      endcase
      r.code  = model_code;
      r.valid = is_rotation(model_code);
      r.face  = face_at(model_code, fq);
      predicted_results.push_back(r);
   endtask

   // ------------------------------------------------------- result checking

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      rotation_result_type r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, code %0d",
                                      rsp_code_out));
         end else begin
            r = predicted_results.pop_front();
            if (rsp_code_out !== r.code)
               report_mismatch($sformatf("code_out %0d, expected %0d",
                                         rsp_code_out, r.code));
            if (rsp_is_valid !== r.valid)
               report_mismatch($sformatf("is_valid %0b, expected %0b for code %0d",
                                         rsp_is_valid, r.valid, r.code));
            if (rsp_face_image !== r.face)
               report_mismatch($sformatf("face_image %0d, expected %0d for code %0d",
                                         rsp_face_image, r.face, r.code));
         end
      end
   end

   // ------------------------------------------------------------- receiver

   initial begin : receiver
      int burst;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (receiver_idle_en && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 8);
            rsp_ready <= 1'b0;
            repeat (burst) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // --------------------------------------------------------------- sender

   task automatic send_item(input logic [2:0] cmd, input code_type op, input turns_type n,
                            input tindex_type idx, input field_type fq);
      int gap;
      if (sender_idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_code_operand <= op;
      req_turns        <= n;
      req_table_index  <= idx;
      req_face_query   <= fq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_rotation(cmd, op, n, idx, fq);
   endtask

   // Stops offering items until every predicted result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (predicted_results.size() != 0);
   endtask

   // Mostly well-formed commands on valid codes, with some loads of arbitrary
   // codes and spare commands mixed in. Unused fields carry random values.
   task automatic send_random_item();
      logic [2:0] cmd;
      code_type   op;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      op   = code_type'($urandom_range(0, 262143));
      if (pick < 8)       cmd = CMD_LOAD;
      else if (pick < 14) begin
         cmd = CMD_LOAD;
         op  = VALID_CODES[$urandom_range(0, NumCodes - 1)];
      end
      else if (pick < 28) cmd = CMD_TLOAD;
      else if (pick < 42) cmd = CMD_ROT_X;
      else if (pick < 56) cmd = CMD_ROT_Y;
      else if (pick < 70) cmd = CMD_ROT_Z;
      else if (pick < 84) begin
         cmd = CMD_COMPOSE;
         if ($urandom_range(0, 3) != 0) op = VALID_CODES[$urandom_range(0, NumCodes - 1)];
      end
      else if (pick < 96) cmd = CMD_QUERY;
      else                cmd = CMD_SPARE;
      send_item(cmd, op, turns_type'($urandom_range(0, 3)),
                tindex_type'($urandom_range(0, 31)), field_type'($urandom_range(0, 7)));
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      send_item(CMD_QUERY, '0, 2'd0, 5'd0, 3'd0);
      send_item(CMD_QUERY, '1, 2'd3, 5'd31, 3'd7);
      send_item(CMD_SPARE, '0, 2'd0, 5'd0, 3'd6);
      send_item(CMD_LOAD, 18'd0, 2'd0, 5'd0, 3'd5);
      send_item(CMD_LOAD, 18'd262143, 2'd0, 5'd0, 3'd3);
      send_item(CMD_ROT_X, '0, 2'd1, 5'd0, 3'd2);
      send_item(CMD_COMPOSE, 18'd262143, 2'd0, 5'd0, 3'd1);
      send_item(CMD_TLOAD, '0, 2'd0, 5'd0, 3'd0);
      send_item(CMD_TLOAD, '0, 2'd0, 5'd23, 3'd4);
      send_item(CMD_TLOAD, '0, 2'd0, 5'd24, 3'd5);
      send_item(CMD_TLOAD, '0, 2'd0, 5'd31, 3'd1);
      send_item(CMD_ROT_X, '0, 2'd0, 5'd0, 3'd2);
      send_item(CMD_ROT_X, '0, 2'd1, 5'd0, 3'd3);
      send_item(CMD_ROT_X, '0, 2'd2, 5'd0, 3'd4);
      send_item(CMD_ROT_X, '0, 2'd3, 5'd0, 3'd5);
      send_item(CMD_ROT_Y, '0, 2'd1, 5'd0, 3'd0);
      send_item(CMD_ROT_Y, '0, 2'd2, 5'd0, 3'd1);
      send_item(CMD_ROT_Z, '0, 2'd1, 5'd0, 3'd2);
      send_item(CMD_ROT_Z, '0, 2'd3, 5'd0, 3'd3);
      send_item(CMD_COMPOSE, HOME_CODE, 2'd0, 5'd0, 3'd4);
      send_item(CMD_COMPOSE, 18'd106597, 2'd0, 5'd0, 3'd5);
      send_item(CMD_COMPOSE, 18'd0, 2'd0, 5'd0, 3'd0);
      send_item(CMD_LOAD, 18'd106597, 2'd0, 5'd0, 3'd7);
   endtask

   task automatic test_random(input int unsigned count);
      repeat (count) send_random_item();
   endtask

   // The result side stops for a long stretch while items keep coming, so the
   // unit fills up and has to stall its input.
   task automatic test_long_hold();
      sender_idle_en = 1'b0;
      long_hold_req  = 1'b1;
      repeat (30) send_random_item();
      sender_idle_en = 1'b1;
   endtask

   task automatic test_drain_pause();
      repeat (15) send_random_item();
      wait_drained();
      repeat (15) send_random_item();
   endtask

   task automatic test_full_rate(input int unsigned count);
      sender_idle_en   = 1'b0;
      receiver_idle_en = 1'b0;
      repeat (count) send_random_item();
   endtask

   initial begin
      model_code = HOME_CODE;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(200);
      test_long_hold();
      test_drain_pause();
      test_random(100);
      test_full_rate(40);
      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/crcu_pkg.sv
design/crcu_next.sv
design/crcu_status.sv
design/cube_rotation_code_unit.sv
test/cube_rotation_code_unit_tb.sv
